### hdl/arbc_pkg.sv
package arbc_pkg;

    // Field widths
    localparam int LEVEL_W  = 10;
    localparam int SLOT_W   = 2;
    localparam int STEP_W   = 8;
    localparam int ADJ_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int OFF_W    = 9;
    localparam int COLOR_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Working width for threshold and offset arithmetic
    localparam int CALC_W = 19;

    localparam int NUM_SLOTS_DEF = 3;

    // Opcodes
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_STEP = 2'd3;

    // Register reset values
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST  = 10'd750;
    localparam logic [STEP_W-1:0]  COLOR_STEP_RST = 8'd10;
    localparam logic [STEP_W-1:0]  WHITE_STEP_RST = 8'd2;
    localparam logic [STEP_W-1:0]  BLACK_STEP_RST = 8'd10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [COLOR_W-1:0] {
        COL_NONE   = 3'd0,
        COL_RED    = 3'd1,
        COL_BLACK  = 3'd2,
        COL_BLUE   = 3'd3,
        COL_YELLOW = 3'd4,
        COL_GREEN  = 3'd5,
        COL_WHITE  = 3'd6
    } t_color;

    // Per-slot sensor offsets; the fourth entry serves slots without offsets
    localparam logic signed [OFF_W-1:0] OFF_R [4] = '{-9'sd150, -9'sd25, -9'sd50, 9'sd0};
    localparam logic signed [OFF_W-1:0] OFF_G [4] = '{-9'sd100, -9'sd100, 9'sd100, 9'sd0};
    localparam logic signed [OFF_W-1:0] OFF_B [4] = '{9'sd150, 9'sd125, -9'sd50, 9'sd0};

    typedef struct packed {
        logic               opcode;
        logic [SLOT_W-1:0]  slot;
        logic [LEVEL_W-1:0] dark_level;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] white_level;
        logic [LEVEL_W-1:0] ambient_level;
    } t_item;

    typedef struct packed {
        logic [COLOR_W-1:0] ball_color;
        logic [COUNT_W-1:0] slot_attempts;
        logic               fallback_used;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] threshold;
        logic [STEP_W-1:0]  color_step;
        logic [STEP_W-1:0]  white_step;
        logic [STEP_W-1:0]  black_step;
    } t_settings;

    typedef struct packed {
        logic signed [ADJ_W-1:0] red;
        logic signed [ADJ_W-1:0] green;
        logic signed [ADJ_W-1:0] blue;
        logic signed [ADJ_W-1:0] white;
    } t_adjust;

    typedef struct packed {
        t_color  color;
        logic    fallback;
        t_adjust adj;
    } t_verdict;

    function automatic logic signed [CALC_W-1:0] ext_u(input logic [LEVEL_W-1:0] v);
        return {{(CALC_W-LEVEL_W){1'b0}}, v};
    endfunction

    function automatic logic signed [CALC_W-1:0] ext_step(input logic [STEP_W-1:0] v);
        return {{(CALC_W-STEP_W){1'b0}}, v};
    endfunction

    function automatic logic signed [CALC_W-1:0] ext_off(input logic signed [OFF_W-1:0] v);
        return {{(CALC_W-OFF_W){v[OFF_W-1]}}, v};
    endfunction

    function automatic logic signed [CALC_W-1:0] ext_adj(input logic signed [ADJ_W-1:0] v);
        return {{(CALC_W-ADJ_W){v[ADJ_W-1]}}, v};
    endfunction

    // Clamp to the 16-bit two's complement range
    function automatic logic signed [ADJ_W-1:0] sat_adj(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] hi;
        logic signed [CALC_W-1:0] lo;
        hi = {{(CALC_W-ADJ_W+1){1'b0}}, {(ADJ_W-1){1'b1}}};
        lo = {{(CALC_W-ADJ_W+1){1'b1}}, {(ADJ_W-1){1'b0}}};
        if (v > hi) begin
            return hi[ADJ_W-1:0];
        end else if (v < lo) begin
            return lo[ADJ_W-1:0];
        end else begin
            return v[ADJ_W-1:0];
        end
    endfunction

endpackage

### hdl/arbc_stream_if.sv
interface arbc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/arbc_classify.sv
module arbc_classify (
    input  arbc_pkg::t_item     i_item,
    input  arbc_pkg::t_settings i_set,
    input  arbc_pkg::t_adjust   i_adj,
    output arbc_pkg::t_verdict  o_verdict
);
    import arbc_pkg::*;

    logic signed [CALC_W-1:0] th;
    logic signed [CALC_W-1:0] ro, go, bo;
    logic signed [CALC_W-1:0] red_s, green_s, blue_s, white_s;
    logic signed [CALC_W-1:0] rt, gt, bt;
    logic signed [CALC_W-1:0] st, ws, bs;
    logic                     flag_r, flag_g, flag_b, flag_w;
    logic [3:0]               pattern;
    t_color                   decoded;

    // Widen readings, offsets, threshold and steps, and form the corrected readings
    always_comb begin
        th      = ext_u(i_set.threshold);
        ro      = ext_off(OFF_R[i_item.slot]);
        go      = ext_off(OFF_G[i_item.slot]);
        bo      = ext_off(OFF_B[i_item.slot]);
        red_s   = ext_u(i_item.red_level);
        green_s = ext_u(i_item.green_level);
        blue_s  = ext_u(i_item.blue_level);
        white_s = ext_u(i_item.white_level);
        st      = ext_step(i_set.color_step);
        ws      = ext_step(i_set.white_step);
        bs      = ext_step(i_set.black_step);
        rt      = red_s + ro;
        gt      = green_s + go;
        bt      = blue_s + bo;
    end

    // Compare against the adjusted thresholds
    always_comb begin
        flag_r  = (red_s - ro) < (th - ext_adj(i_adj.red));
        flag_g  = (green_s - go) < (th - ext_adj(i_adj.green));
        flag_b  = (blue_s - bo) < (th - ext_adj(i_adj.blue));
        flag_w  = white_s < (th - ext_adj(i_adj.white));
        pattern = {flag_r, flag_g, flag_b, flag_w};
    end

    // Decode the flag pattern
    always_comb begin
        unique case (pattern)
            4'b1001: decoded = COL_RED;
            4'b0000: decoded = COL_BLACK;
            4'b0011: decoded = COL_BLUE;
            4'b1101: decoded = COL_YELLOW;
            4'b0101: decoded = COL_GREEN;
            4'b1111: decoded = COL_WHITE;
            default: decoded = COL_NONE;
        endcase
    end

    // Pick the colour and the next adjustments
    always_comb begin
        o_verdict.color    = COL_NONE;
        o_verdict.fallback = 1'b0;
        o_verdict.adj      = i_adj;
        if (i_item.opcode == OP_CLASSIFY && i_item.dark_level > i_item.ambient_level) begin
            if (decoded != COL_NONE) begin
                o_verdict.color = decoded;
                o_verdict.adj   = '0;
            end else begin
                o_verdict.fallback = 1'b1;
                priority if (rt < gt && rt < bt) begin
                    o_verdict.color     = COL_RED;
                    o_verdict.adj.red   = sat_adj(ext_adj(i_adj.red) - st);
                    o_verdict.adj.green = sat_adj(ext_adj(i_adj.green) + st);
                    o_verdict.adj.blue  = sat_adj(ext_adj(i_adj.blue) + st);
                    o_verdict.adj.white = sat_adj(ext_adj(i_adj.white) - ws);
                end else if (gt < rt && gt < bt) begin
                    o_verdict.color     = COL_GREEN;
                    o_verdict.adj.red   = sat_adj(ext_adj(i_adj.red) + st);
                    o_verdict.adj.green = sat_adj(ext_adj(i_adj.green) - st);
                    o_verdict.adj.blue  = sat_adj(ext_adj(i_adj.blue) + st);
                    o_verdict.adj.white = sat_adj(ext_adj(i_adj.white) - ws);
                end else if (bt < rt && bt < gt) begin
                    o_verdict.color     = COL_BLUE;
                    o_verdict.adj.red   = sat_adj(ext_adj(i_adj.red) + st);
                    o_verdict.adj.green = sat_adj(ext_adj(i_adj.green) + st);
                    o_verdict.adj.blue  = sat_adj(ext_adj(i_adj.blue) - st);
                    o_verdict.adj.white = sat_adj(ext_adj(i_adj.white) - ws);
                end else begin
                    o_verdict.color     = COL_BLACK;
                    o_verdict.adj.red   = '0;
                    o_verdict.adj.green = '0;
                    o_verdict.adj.blue  = '0;
                    o_verdict.adj.white = sat_adj(ext_adj(i_adj.white) - bs);
                end
            end
        end
    end

endmodule

### hdl/arbc_counters.sv
module arbc_counters #(
    parameter int NUM_SLOTS = arbc_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_count,
    input  logic                          i_clear,
    input  logic [arbc_pkg::SLOT_W-1:0]   i_slot,
    output logic [arbc_pkg::COUNT_W-1:0]  o_attempts
);
    import arbc_pkg::*;

    logic [COUNT_W-1:0] r_count [NUM_SLOTS];
    logic [COUNT_W-1:0] n_count [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] hit;

    // Work out each slot's count after this word
    always_comb begin
        o_attempts = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            hit[i]     = (32'(i_slot) == i);
            n_count[i] = r_count[i];
            if (hit[i] && r_count[i] != COUNT_MAX) begin
                n_count[i] = r_count[i] + 1'b1;
            end
            if (hit[i] && !i_clear) begin
                o_attempts = o_attempts | n_count[i];
            end
        end
    end

    // Hold, advance or clear the counters
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!i_rst_n || i_clear) begin
                r_count[i] <= '0;
            end else if (i_count) begin
                r_count[i] <= n_count[i];
            end
        end
    end

endmodule

### hdl/adaptive_rgb_ball_color_classifier.sv
// A taken word waits in the input register, is classified from there and, once the result
// register is free, is written to it and offered as a result until it is taken.
// Throughput: one word per cycle unless stalled; adjustment feedback closes in classify.
// Stalls on the result side back up through one input register and one result register.
// Reset (synchronous, active low): adjustments and attempt counters go to zero and the
// settings take their default values; the configuration channel is always ready.
module adaptive_rgb_ball_color_classifier #(
    parameter int NUM_SLOTS = arbc_pkg::NUM_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    arbc_stream_if.sink   i_in,
    arbc_stream_if.source o_res,
    arbc_stream_if.sink   i_cfg
);
    import arbc_pkg::*;

    t_item              r_in;
    logic               r_in_valid;
    t_result            r_out;
    logic               r_out_valid;
    t_settings          r_set;
    t_adjust            r_adj;
    t_verdict           verdict;
    logic               advance;
    logic [COUNT_W-1:0] attempts;

    // Move the held word on when the result register is free
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    arbc_classify u_classify (
        .i_item    (r_in),
        .i_set     (r_set),
        .i_adj     (r_adj),
        .o_verdict (verdict)
    );

    arbc_counters #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_count    (advance && r_in.opcode == OP_CLASSIFY),
        .i_clear    (advance && r_in.opcode == OP_CLEAR),
        .i_slot     (r_in.slot),
        .o_attempts (attempts)
    );

    // Control state, settings and adjustments
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_adj            <= '0;
            r_set.threshold  <= THRESHOLD_RST;
            r_set.color_step <= COLOR_STEP_RST;
            r_set.white_step <= WHITE_STEP_RST;
            r_set.black_step <= BLACK_STEP_RST;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_adj       <= verdict.adj;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_THRESHOLD:  r_set.threshold  <= i_cfg.data.value;
                    REG_COLOR_STEP: r_set.color_step <= i_cfg.data.value[STEP_W-1:0];
                    REG_WHITE_STEP: r_set.white_step <= i_cfg.data.value[STEP_W-1:0];
                    REG_BLACK_STEP: r_set.black_step <= i_cfg.data.value[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Capture the input word and the result
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out.ball_color    <= verdict.color;
            r_out.slot_attempts <= attempts;
            r_out.fallback_used <= verdict.fallback;
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import arbc_pkg::*;

    localparam int          SLOTS       = 3;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          BULK_ITEMS  = 60;
    localparam int          PHASE_ITEMS = 220;

    // Sensor offsets per slot; the last entry serves slots without offsets
    localparam int RED_OFS   [4] = '{-150, -25, -50, 0};
    localparam int GREEN_OFS [4] = '{-100, -100, 100, 0};
    localparam int BLUE_OFS  [4] = '{150, 125, -50, 0};

    logic i_clk;
    logic i_rst_n;

    arbc_stream_if #(.T(t_item))   reading_if ();
    arbc_stream_if #(.T(t_result)) verdict_if ();
    arbc_stream_if #(.T(t_cfg))    setting_if ();

    adaptive_rgb_ball_color_classifier #(.NUM_SLOTS(SLOTS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (reading_if),
        .o_res   (verdict_if),
        .i_cfg   (setting_if)
    );

    // Mirror of the settings and learned state
    int unsigned cur_threshold;
    int unsigned cur_color_step;
    int unsigned cur_white_step;
    int unsigned cur_black_step;
    int          adj_red;
    int          adj_green;
    int          adj_blue;
    int          adj_white;
    int unsigned slot_tries [SLOTS];

    t_item       pending_readings [$];
    t_result     expected_verdicts [$];
    int unsigned readings_queued;
    int unsigned readings_taken;
    int unsigned verdicts_checked;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned colour_seen [8];
    int unsigned fallbacks_seen;
    int unsigned settings_used;
    bit          reading_fired;
    bit          idle_on;
    bit          hold_armed;
    bit          hold_done;
    int          hold_left;
    int          send_gap;
    int          stall_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_adjust(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(int v);
        if (v < 0) return '0;
        if (v > 1023) return LEVEL_W'(1023);
        return LEVEL_W'(v);
    endfunction

    // Work out the verdict for one word and advance the mirrored state
    function automatic t_result classify_reading(t_item rd);
        t_result    res;
        t_color     col;
        logic [3:0] flags;
        int         sl;
        int         th;
        int         ro;
        int         go;
        int         bo;
        int         rt;
        int         gt;
        int         bt;
        int         st;
        int         ws;
        res = '0;
        if (rd.opcode == OP_CLEAR) begin
            foreach (slot_tries[i]) slot_tries[i] = 0;
            return res;
        end
        sl = int'(rd.slot);
        if (sl < SLOTS) begin
            if (slot_tries[sl] < 65535) slot_tries[sl]++;
            res.slot_attempts = 16'(slot_tries[sl]);
        end
        // no ball unless the dark reading rises above ambient
        if (rd.dark_level <= rd.ambient_level) return res;

        th = int'(cur_threshold);
        ro = RED_OFS[sl];
        go = GREEN_OFS[sl];
        bo = BLUE_OFS[sl];
        flags[3] = (int'(rd.red_level) - ro) < (th - adj_red);
        flags[2] = (int'(rd.green_level) - go) < (th - adj_green);
        flags[1] = (int'(rd.blue_level) - bo) < (th - adj_blue);
        flags[0] = int'(rd.white_level) < (th - adj_white);
        case (flags)
            4'b1001: col = COL_RED;
            4'b0000: col = COL_BLACK;
            4'b0011: col = COL_BLUE;
            4'b1101: col = COL_YELLOW;
            4'b0101: col = COL_GREEN;
            4'b1111: col = COL_WHITE;
            default: col = COL_NONE;
        endcase

        if (col != COL_NONE) begin
            adj_red   = 0;
            adj_green = 0;
            adj_blue  = 0;
            adj_white = 0;
        end else begin
            // fall back to the strictly smallest corrected reading
            rt = int'(rd.red_level) + ro;
            gt = int'(rd.green_level) + go;
            bt = int'(rd.blue_level) + bo;
            st = int'(cur_color_step);
            ws = int'(cur_white_step);
            res.fallback_used = 1'b1;
            if (rt < gt && rt < bt) begin
                adj_red   = clamp_adjust(adj_red - st);
                adj_green = clamp_adjust(adj_green + st);
                adj_blue  = clamp_adjust(adj_blue + st);
                adj_white = clamp_adjust(adj_white - ws);
                col = COL_RED;
            end else if (gt < rt && gt < bt) begin
                adj_green = clamp_adjust(adj_green - st);
                adj_red   = clamp_adjust(adj_red + st);
                adj_blue  = clamp_adjust(adj_blue + st);
                adj_white = clamp_adjust(adj_white - ws);
                col = COL_GREEN;
            end else if (bt < rt && bt < gt) begin
                adj_blue  = clamp_adjust(adj_blue - st);
                adj_red   = clamp_adjust(adj_red + st);
                adj_green = clamp_adjust(adj_green + st);
                adj_white = clamp_adjust(adj_white - ws);
                col = COL_BLUE;
            end else begin
                adj_red   = 0;
                adj_green = 0;
                adj_blue  = 0;
                adj_white = clamp_adjust(adj_white - int'(cur_black_step));
                col = COL_BLACK;
            end
        end
        res.ball_color = col;
        return res;
    endfunction

    function automatic t_item make_reading(logic op, logic [SLOT_W-1:0] sl,
                                           int dark, int amb, int r, int g, int b, int w);
        t_item rd;
        rd.opcode        = op;
        rd.slot          = sl;
        rd.dark_level    = clamp_level(dark);
        rd.ambient_level = clamp_level(amb);
        rd.red_level     = clamp_level(r);
        rd.green_level   = clamp_level(g);
        rd.blue_level    = clamp_level(b);
        rd.white_level   = clamp_level(w);
        return rd;
    endfunction

    // Reading spread around where its flag flips, sometimes anywhere
    function automatic logic [LEVEL_W-1:0] near_level(int centre);
        int v;
        if ($urandom_range(0, 4) == 0) return LEVEL_W'($urandom);
        v = centre + int'($urandom_range(0, 500)) - 250;
        return clamp_level(v);
    endfunction

    function automatic t_item random_reading(int fixed_slot);
        t_item rd;
        int    th;
        int    sl;
        th = int'(cur_threshold);
        rd.opcode = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_CLASSIFY;
        if (fixed_slot >= 0) begin
            rd.opcode = OP_CLASSIFY;
            rd.slot   = SLOT_W'(fixed_slot);
        end else if ($urandom_range(0, 7) == 0) begin
            rd.slot = SLOT_W'(3);
        end else begin
            rd.slot = SLOT_W'($urandom_range(0, 2));
        end
        if ($urandom_range(0, 9) == 0) begin
            rd.dark_level    = LEVEL_W'($urandom);
            rd.ambient_level = LEVEL_W'($urandom);
        end else begin
            rd.dark_level    = LEVEL_W'($urandom_range(1, 1023));
            rd.ambient_level = LEVEL_W'($urandom_range(0, int'(rd.dark_level) - 1));
        end
        sl = int'(rd.slot);
        rd.red_level   = near_level(th + RED_OFS[sl]);
        rd.green_level = near_level(th + GREEN_OFS[sl]);
        rd.blue_level  = near_level(th + BLUE_OFS[sl]);
        rd.white_level = near_level(th);
        // force a red/green tie now and then to reach the black fallback
        if ($urandom_range(0, 7) == 0) begin
            rd.green_level = clamp_level(int'(rd.red_level) + RED_OFS[sl] - GREEN_OFS[sl]);
        end
        return rd;
    endfunction

    task automatic queue_reading(t_item rd);
        pending_readings.push_back(rd);
        readings_queued++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("[%0t] verdict %0d %s: got %0d, expected %0d",
                 $realtime, verdicts_checked, what, got, want);
    endtask

    // Wait until every word is taken and every verdict has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (readings_taken != readings_queued || expected_verdicts.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        t_cfg word;
        word.index = idx;
        word.value = CFG_DAT_W'(value);
        @(negedge i_clk);
        setting_if.valid <= 1'b1;
        setting_if.data  <= word;
        do @(posedge i_clk); while (!setting_if.ready);
        case (idx)
            REG_THRESHOLD:  cur_threshold  = value & 32'h3FF;
            REG_COLOR_STEP: cur_color_step = value & 32'hFF;
            REG_WHITE_STEP: cur_white_step = value & 32'hFF;
            REG_BLACK_STEP: cur_black_step = value & 32'hFF;
            default: ;
        endcase
        @(negedge i_clk);
        setting_if.valid <= 1'b0;
    endtask

    // Drain, load a new set of settings, then open the next phase
    task automatic start_phase(int unsigned th, int unsigned cs, int unsigned ws,
                               int unsigned bs, bit idle);
        wait_idle();
        write_setting(REG_THRESHOLD, th);
        write_setting(REG_COLOR_STEP, cs);
        write_setting(REG_WHITE_STEP, ws);
        write_setting(REG_BLACK_STEP, bs);
        settings_used++;
        @(posedge i_clk);
        idle_on = idle;
    endtask

    // Predict each word as it is taken
    always @(posedge i_clk) begin
        reading_fired = 1'b0;
        if (i_rst_n && reading_if.valid && reading_if.ready) begin
            expected_verdicts.push_back(classify_reading(reading_if.data));
            readings_taken++;
            reading_fired = 1'b1;
        end
    end

    // Offer pending words, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            reading_if.valid <= 1'b0;
            send_gap = 0;
        end else if (reading_if.valid && !reading_fired) begin
            // hold the word until it is taken
        end else if (send_gap > 0) begin
            send_gap--;
            reading_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 15);
            reading_if.valid <= 1'b0;
        end else if (pending_readings.size() > 0) begin
            reading_if.valid <= 1'b1;
            reading_if.data  <= pending_readings.pop_front();
        end else begin
            reading_if.valid <= 1'b0;
        end
    end

    // Hold off the result side once for a long stretch
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
    end

    // Stall the result side in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            verdict_if.ready <= 1'b0;
            stall_left = 0;
        end else if (hold_left > 0) begin
            verdict_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            verdict_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            verdict_if.ready <= 1'b0;
        end else begin
            verdict_if.ready <= 1'b1;
        end
    end

    // Compare each verdict with the oldest prediction
    always @(posedge i_clk) begin : check_verdicts
        t_result want;
        if (i_rst_n && verdict_if.valid && verdict_if.ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected verdict, ball_color", verdict_if.data.ball_color, 0);
            end else begin
                want = expected_verdicts.pop_front();
                if (verdict_if.data.ball_color !== want.ball_color)
                    report_mismatch("ball_color", verdict_if.data.ball_color, want.ball_color);
                if (verdict_if.data.slot_attempts !== want.slot_attempts)
                    report_mismatch("slot_attempts", verdict_if.data.slot_attempts,
                                    want.slot_attempts);
                if (verdict_if.data.fallback_used !== want.fallback_used)
                    report_mismatch("fallback_used", verdict_if.data.fallback_used,
                                    want.fallback_used);
                colour_seen[want.ball_color]++;
                if (want.fallback_used) fallbacks_seen++;
            end
            verdicts_checked++;
        end
    end

    // Give up once the run passes the cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d verdicts outstanding",
                     cycle_count, expected_verdicts.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        reading_if.valid    = 1'b0;
        reading_if.data     = '0;
        verdict_if.ready    = 1'b0;
        setting_if.valid    = 1'b0;
        setting_if.data     = '0;
        cur_threshold       = 750;
        cur_color_step      = 10;
        cur_white_step      = 2;
        cur_black_step      = 10;
        adj_red             = 0;
        adj_green           = 0;
        adj_blue            = 0;
        adj_white           = 0;
        foreach (slot_tries[i]) slot_tries[i] = 0;
        idle_on             = 1'b1;
        hold_armed          = 1'b0;
        settings_used       = 1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings
        queue_reading(make_reading(OP_CLEAR, 2, 1023, 0, 1023, 1023, 1023, 1023));
        queue_reading(make_reading(OP_CLASSIFY, 0, 512, 512, 100, 1023, 1023, 0));
        queue_reading(make_reading(OP_CLASSIFY, 1, 0, 1023, 0, 0, 0, 0));
        queue_reading(make_reading(OP_CLASSIFY, 0, 1023, 0, 100, 1023, 1023, 0));
        queue_reading(make_reading(OP_CLASSIFY, 0, 1023, 0, 1023, 1023, 1023, 1023));
        queue_reading(make_reading(OP_CLASSIFY, 0, 700, 10, 1023, 1023, 0, 0));
        queue_reading(make_reading(OP_CLASSIFY, 0, 700, 10, 0, 0, 1023, 0));
        queue_reading(make_reading(OP_CLASSIFY, 0, 700, 10, 1023, 0, 1023, 0));
        queue_reading(make_reading(OP_CLASSIFY, 0, 700, 10, 0, 0, 0, 0));
        // fallback to red, green and blue in turn, then a tie to black
        queue_reading(make_reading(OP_CLASSIFY, 0, 900, 100, 0, 1023, 1023, 1023));
        queue_reading(make_reading(OP_CLASSIFY, 0, 900, 100, 1023, 0, 1023, 1023));
        queue_reading(make_reading(OP_CLASSIFY, 0, 900, 100, 1023, 1023, 0, 1023));
        queue_reading(make_reading(OP_CLASSIFY, 3, 900, 100, 100, 100, 100, 1023));
        queue_reading(random_reading(1));
        queue_reading(random_reading(2));
        queue_reading(make_reading(OP_CLASSIFY, 3, 1023, 1022, 0, 0, 0, 0));
        queue_reading(make_reading(OP_CLASSIFY, 1, 1023, 1022, 0, 0, 0, 0));
        queue_reading(make_reading(OP_CLEAR, 1, 0, 0, 0, 0, 0, 0));
        queue_reading(make_reading(OP_CLASSIFY, 2, 1023, 0, 512, 512, 512, 512));
        queue_reading(make_reading(OP_CLASSIFY, 0, 1023, 0, 0, 0, 0, 0));

        // Drive the adjustments into saturation at both ends
        start_phase(1023, 255, 0, 255, 1'b1);
        repeat (135) begin
            queue_reading(make_reading(OP_CLASSIFY, 3, $urandom_range(600, 1023),
                                       $urandom_range(0, 599), $urandom_range(0, 1000),
                                       1023, 1023, 1023));
        end
        repeat (135) begin
            queue_reading(make_reading(OP_CLASSIFY, 3, $urandom_range(600, 1023),
                                       $urandom_range(0, 599), 1023, 1023, 1023,
                                       $urandom_range(0, 1022)));
        end

        // Zero threshold and zero steps
        start_phase(0, 0, 0, 0, 1'b1);
        repeat (100) queue_reading(random_reading(-1));

        // Keep one slot busy back to back between two clears
        start_phase(750, 10, 2, 10, 1'b0);
        queue_reading(make_reading(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        repeat (BULK_ITEMS) queue_reading(random_reading(1));
        queue_reading(make_reading(OP_CLEAR, 3, 1023, 0, 0, 0, 0, 0));

        // Random settings, with one long hold-off on the result side
        for (int p = 0; p < 5; p++) begin
            start_phase($urandom_range(300, 900), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
            repeat (PHASE_ITEMS) queue_reading(random_reading(-1));
            if (p == 0) begin
                @(negedge i_clk);
                hold_armed = 1'b1;
            end
        end

        // Back to the reset settings, flat out
        start_phase(750, 10, 2, 10, 1'b0);
        repeat (100) queue_reading(random_reading(-1));

        wait_idle();
        $display("Checked %0d verdicts (%0d from the fallback) over %0d sets of settings",
                 verdicts_checked, fallbacks_seen, settings_used);
        $display("Colours: none %0d red %0d black %0d blue %0d yellow %0d green %0d white %0d",
                 colour_seen[COL_NONE], colour_seen[COL_RED], colour_seen[COL_BLACK],
                 colour_seen[COL_BLUE], colour_seen[COL_YELLOW], colour_seen[COL_GREEN],
                 colour_seen[COL_WHITE]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/arbc_pkg.sv
hdl/arbc_stream_if.sv
hdl/arbc_classify.sv
hdl/arbc_counters.sv
hdl/adaptive_rgb_ball_color_classifier.sv
tb/sv/testbench.sv
